FILE: design/rts_cts_mailbox_handshake_top_macros.svh
// Assertion macros shared by the mailbox handshake RTL.
// Needs only a clock, a reset and the expressions passed in.
`ifndef RTS_CTS_MAILBOX_HANDSHAKE_TOP_MACROS_SVH
`define RTS_CTS_MAILBOX_HANDSHAKE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define RCM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RCM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/rcm_pkg.sv
// Shared types, event codes, message kinds and state codes of the mailbox handshake.
// No dependencies; used by the channel interfaces and the top level.
package rcm_pkg;

   // Queue and id sizing
   localparam int QUEUE_DEPTH = 16;
   localparam int ID_WIDTH    = 8;
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // Field widths of the channels
   localparam int CMD_W   = 4;
   localparam int KIND_W  = 3;
   localparam int STATE_W = 3;
   localparam int FID_W   = 8;
   localparam int TAG_W   = 16;
   localparam int COUNT_W = 5;

   typedef logic [CMD_W-1:0]   cmd_type;
   typedef logic [KIND_W-1:0]  kind_type;
   typedef logic [STATE_W-1:0] state_type;
   typedef logic [FID_W-1:0]   id_type;
   typedef logic [TAG_W-1:0]   tag_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [PTR_W-1:0]   ptr_type;
   typedef logic [CNT_W-1:0]   fill_type;

   // Ids are held to ID_WIDTH bits
   localparam id_type ID_MASK = FID_W'((64'd1 << ID_WIDTH) - 64'd1);

   // Event codes
   localparam cmd_type CMD_START_RX      = 4'd0;
   localparam cmd_type CMD_START_RX_NOQ  = 4'd1;
   localparam cmd_type CMD_START_CLESS   = 4'd2;
   localparam cmd_type CMD_RTS_IN        = 4'd3;
   localparam cmd_type CMD_INIT_SEND     = 4'd4;
   localparam cmd_type CMD_HOLD_IN       = 4'd5;
   localparam cmd_type CMD_CTS_IN        = 4'd6;
   localparam cmd_type CMD_ACK_IN        = 4'd7;
   localparam cmd_type CMD_VALID_MSG     = 4'd8;
   localparam cmd_type CMD_VALID_CLESS   = 4'd9;
   localparam cmd_type CMD_RST_Q_EMPTY   = 4'd10;
   localparam cmd_type CMD_RST_Q_PENDING = 4'd11;
   localparam cmd_type CMD_TIMEOUT       = 4'd12;
   localparam cmd_type CMD_RESTART       = 4'd13;

   // Outgoing message kinds
   localparam kind_type KIND_HOLD = 3'd0;
   localparam kind_type KIND_RTS  = 3'd1;
   localparam kind_type KIND_CTS  = 3'd2;
   localparam kind_type KIND_ACK  = 3'd3;
   localparam kind_type KIND_DATA = 3'd4;

   // Handshake states
   localparam state_type ST_IDLE_EMPTY  = 3'd0;
   localparam state_type ST_IDLE_QUEUED = 3'd1;
   localparam state_type ST_RTS_SENT    = 3'd2;
   localparam state_type ST_HOLD        = 3'd3;
   localparam state_type ST_WAIT_ACK    = 3'd4;
   localparam state_type ST_WAIT_RTS    = 3'd5;
   localparam state_type ST_WAIT_MSG    = 3'd6;
   localparam state_type ST_ENDED       = 3'd7;

endpackage

FILE: design/rcm_channels.sv
// Valid/ready channel interfaces for handshake events and results.
// Depends on rcm_pkg for the payload types.
interface rcm_req_if;
   import rcm_pkg::*;

   logic    valid;
   logic    ready;
   cmd_type cmd;
   id_type  source_id;
   id_type  dest_id;
   tag_type message_tag;

   modport source (output valid, output cmd, output source_id, output dest_id,
                   output message_tag, input ready);
   modport sink   (input valid, input cmd, input source_id, input dest_id,
                   input message_tag, output ready);
endinterface

interface rcm_rsp_if;
   import rcm_pkg::*;

   logic      valid;
   logic      ready;
   logic      send_valid;
   kind_type  send_kind;
   id_type    send_dest;
   tag_type   send_tag;
   state_type state_now;
   logic      finished;
   logic      accepted;
   logic      queue_fault;
   logic      receive_override;
   tag_type   buffer_tag;
   id_type    buffer_dest;
   count_type queue_count;

   modport source (output valid, output send_valid, output send_kind, output send_dest,
                   output send_tag, output state_now, output finished, output accepted,
                   output queue_fault, output receive_override, output buffer_tag,
                   output buffer_dest, output queue_count, input ready);
   modport sink   (input valid, input send_valid, input send_kind, input send_dest,
                   input send_tag, input state_now, input finished, input accepted,
                   input queue_fault, input receive_override, input buffer_tag,
                   input buffer_dest, input queue_count, output ready);
endinterface

FILE: design/rts_cts_mailbox_handshake_top.sv
// RTS/CTS/ACK mailbox handshake controller.
// Events arrive on req_if (valid/ready); one result per event leaves on rsp_if.
// Each result carries the outgoing control message, if any (HOLD, RTS, CTS,
// ACK or the buffered data message), plus state, flags, buffer and queue count.
// Each transaction passes through one input register, then one result register.
// Throughput: one event per cycle while rsp_if.ready stays high; the handshake state,
// the buffer and the waiting-sender queue update at the same edge that loads the
// result register, so the next event sees them at once.
// Stall: while rsp_if.ready is low the result register holds, the input register
// still takes one more event, then req_if.ready drops until the result moves.
// Reset (synchronous, active high) empties both registers, returns the state to
// idle with an empty queue and clears flags and buffer. Queue entries keep old
// contents; only the entries from the head up to the fill count are ever read.
// Depends on rcm_pkg, rcm_channels and the macro header.
`include "rts_cts_mailbox_handshake_top_macros.svh"

module rts_cts_mailbox_handshake_top (
   input logic   clock,
   input logic   reset,
   rcm_req_if.sink   req_if,
   rcm_rsp_if.source rsp_if
);
   import rcm_pkg::*;

   // Input register
   logic    s1_valid_ff, s1_valid_in;
   cmd_type s1_cmd_ff;
   id_type  s1_src_ff;
   id_type  s1_dst_ff;
   tag_type s1_tag_ff;

   // Handshake state
   state_type state_ff, state_in;
   logic      done_ff, done_in;
   logic      ovr_ff, ovr_in;
   id_type    tgt_ff, tgt_in;
   tag_type   btag_ff, btag_in;

   // Waiting-sender queue
   id_type    fifo_ff [QUEUE_DEPTH];
   ptr_type   head_ff, head_in;
   fill_type  fill_ff, fill_in;
   ptr_type   tail;
   logic [CNT_W:0] tail_sum;
   logic      push, pop;

   // Result register
   logic      out_valid_ff, out_valid_in;
   logic      tx_valid_ff, tx_valid_in;
   kind_type  tx_kind_ff, tx_kind_in;
   id_type    tx_dest_ff, tx_dest_in;
   tag_type   tx_tag_ff, tx_tag_in;
   logic      ok_ff, ok_in;
   logic      fault_ff, fault_in;

   logic      out_free, adv, take;
   id_type    src_m, dst_m, who;

   // Flow control
   assign out_free     = !out_valid_ff || rsp_if.ready;
   assign adv          = s1_valid_ff && out_free;
   assign req_if.ready = !s1_valid_ff || out_free;
   assign take         = req_if.valid && req_if.ready;
   assign s1_valid_in  = take || (s1_valid_ff && !adv);
   assign out_valid_in = adv || (out_valid_ff && !rsp_if.ready);

   assign src_m = s1_src_ff & ID_MASK;
   assign dst_m = s1_dst_ff & ID_MASK;

   // Tail slot of the queue, wrapped at the depth
   always_comb begin
      tail_sum = (CNT_W+1)'(head_ff) + (CNT_W+1)'(fill_ff);
      if (tail_sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
         tail_sum = tail_sum - (CNT_W+1)'(QUEUE_DEPTH);
      end
      tail = PTR_W'(tail_sum);
   end

   // Decode one event against the current state
   always_comb begin
      state_in    = state_ff;
      done_in     = done_ff;
      ovr_in      = ovr_ff;
      tgt_in      = tgt_ff;
      btag_in     = btag_ff;
      push        = 1'b0;
      pop         = 1'b0;
      ok_in       = 1'b1;
      fault_in    = 1'b0;
      tx_valid_in = 1'b0;
      tx_kind_in  = KIND_HOLD;
      tx_dest_in  = '0;
      tx_tag_in   = '0;
      who         = '0;

      if (s1_cmd_ff == CMD_RESTART) begin
         state_in = ST_IDLE_EMPTY;
      end else if (s1_cmd_ff == CMD_RTS_IN) begin
         if (state_ff == ST_WAIT_RTS) begin
            tx_valid_in = 1'b1;
            tx_kind_in  = KIND_CTS;
            tx_dest_in  = src_m;
            tgt_in      = src_m;
            ovr_in      = 1'b1;
            state_in    = ST_WAIT_MSG;
         end else begin
            // answer HOLD and queue the sender; drop it when the queue is full
            tx_valid_in = 1'b1;
            tx_kind_in  = KIND_HOLD;
            tx_dest_in  = src_m;
            if (fill_ff >= CNT_W'(QUEUE_DEPTH)) begin
               fault_in = 1'b1;
            end else begin
               push = 1'b1;
            end
            if (state_ff == ST_IDLE_EMPTY) begin
               state_in = ST_IDLE_QUEUED;
            end
         end
      end else begin
         unique case (state_ff) inside
            ST_IDLE_EMPTY, ST_IDLE_QUEUED: begin
               if (s1_cmd_ff == CMD_INIT_SEND) begin
                  tgt_in      = dst_m;
                  btag_in     = s1_tag_ff;
                  tx_valid_in = 1'b1;
                  tx_kind_in  = KIND_RTS;
                  tx_dest_in  = dst_m;
                  state_in    = ST_RTS_SENT;
               end else if (s1_cmd_ff == CMD_START_RX_NOQ) begin
                  state_in = ST_WAIT_RTS;
               end else if (s1_cmd_ff == CMD_START_RX) begin
                  if (state_ff == ST_IDLE_EMPTY) begin
                     state_in = ST_WAIT_RTS;
                  end else begin
                     // pop the next sender and clear it to send; empty pop goes to id 0
                     if (fill_ff == '0) begin
                        fault_in = 1'b1;
                     end else begin
                        who = fifo_ff[head_ff];
                        pop = 1'b1;
                     end
                     tx_valid_in = 1'b1;
                     tx_kind_in  = KIND_CTS;
                     tx_dest_in  = who & ID_MASK;
                     tgt_in      = who & ID_MASK;
                     state_in    = ST_WAIT_MSG;
                  end
               end else begin
                  ok_in = 1'b0;
               end
            end
            ST_RTS_SENT, ST_HOLD: begin
               if (s1_cmd_ff == CMD_HOLD_IN && state_ff == ST_RTS_SENT) begin
                  state_in = ST_HOLD;
               end else if (s1_cmd_ff == CMD_CTS_IN) begin
                  tx_valid_in = 1'b1;
                  tx_kind_in  = KIND_DATA;
                  tx_dest_in  = tgt_ff & ID_MASK;
                  tx_tag_in   = btag_ff;
                  state_in    = ST_WAIT_ACK;
               end else if (s1_cmd_ff != CMD_VALID_CLESS) begin
                  ok_in = 1'b0;
               end
            end
            ST_WAIT_ACK: begin
               if (s1_cmd_ff == CMD_ACK_IN) begin
                  done_in  = 1'b1;
                  state_in = ST_ENDED;
               end else if (s1_cmd_ff != CMD_VALID_CLESS) begin
                  ok_in = 1'b0;
               end
            end
            ST_WAIT_RTS: begin
               if (s1_cmd_ff == CMD_TIMEOUT || s1_cmd_ff == CMD_VALID_CLESS) begin
                  tgt_in   = dst_m;
                  btag_in  = s1_tag_ff;
                  done_in  = 1'b1;
                  state_in = ST_ENDED;
               end else begin
                  ok_in = 1'b0;
               end
            end
            ST_WAIT_MSG: begin
               if (s1_cmd_ff == CMD_VALID_MSG) begin
                  tx_valid_in = 1'b1;
                  tx_kind_in  = KIND_ACK;
                  tx_dest_in  = src_m;
                  tgt_in      = dst_m;
                  btag_in     = s1_tag_ff;
                  done_in     = 1'b1;
                  state_in    = ST_ENDED;
               end else if (s1_cmd_ff != CMD_TIMEOUT && s1_cmd_ff != CMD_VALID_CLESS) begin
                  ok_in = 1'b0;
               end
            end
            ST_ENDED: begin
               if (s1_cmd_ff == CMD_RST_Q_EMPTY || s1_cmd_ff == CMD_RST_Q_PENDING) begin
                  done_in  = 1'b0;
                  ovr_in   = 1'b0;
                  tgt_in   = '0;
                  btag_in  = '0;
                  state_in = (s1_cmd_ff == CMD_RST_Q_EMPTY) ? ST_IDLE_EMPTY : ST_IDLE_QUEUED;
               end else begin
                  ok_in = 1'b0;
               end
            end
            default: begin
               ok_in = 1'b0;
            end
         endcase
      end

      // advance the queue pointers
      head_in = head_ff;
      fill_in = fill_ff;
      if (pop) begin
         head_in = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);
         fill_in = fill_ff - CNT_W'(1);
      end else if (push) begin
         fill_in = fill_ff + CNT_W'(1);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= ST_IDLE_EMPTY;
         done_ff      <= 1'b0;
         ovr_ff       <= 1'b0;
         tgt_ff       <= '0;
         btag_ff      <= '0;
         head_ff      <= '0;
         fill_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (adv) begin
            state_ff <= state_in;
            done_ff  <= done_in;
            ovr_ff   <= ovr_in;
            tgt_ff   <= tgt_in;
            btag_ff  <= btag_in;
            head_ff  <= head_in;
            fill_ff  <= fill_in;
         end
      end
   end

   // Payload registers: input stage, queue slots and result
   always_ff @(posedge clock) begin
      if (take) begin
         s1_cmd_ff <= req_if.cmd;
         s1_src_ff <= req_if.source_id;
         s1_dst_ff <= req_if.dest_id;
         s1_tag_ff <= req_if.message_tag;
      end
      if (adv && push) begin
         fifo_ff[tail] <= src_m;
      end
      if (adv) begin
         tx_valid_ff <= tx_valid_in;
         tx_kind_ff  <= tx_kind_in;
         tx_dest_ff  <= tx_dest_in;
         tx_tag_ff   <= tx_tag_in;
         ok_ff       <= ok_in;
         fault_ff    <= fault_in;
      end
   end

   // Drive the result channel
   assign rsp_if.valid            = out_valid_ff;
   assign rsp_if.send_valid       = tx_valid_ff;
   assign rsp_if.send_kind        = tx_kind_ff;
   assign rsp_if.send_dest        = tx_dest_ff;
   assign rsp_if.send_tag         = tx_tag_ff;
   assign rsp_if.state_now        = state_ff;
   assign rsp_if.finished         = done_ff;
   assign rsp_if.accepted         = ok_ff;
   assign rsp_if.queue_fault      = fault_ff;
   assign rsp_if.receive_override = ovr_ff;
   assign rsp_if.buffer_tag       = btag_ff;
   assign rsp_if.buffer_dest      = tgt_ff;
   assign rsp_if.queue_count      = COUNT_W'(fill_ff);

   // Checks
   `RCM_ASSERT_NOW(a_fill_bound, clock, reset, 1'b1,
                   fill_ff <= CNT_W'(QUEUE_DEPTH), "queue fill exceeds depth")
   `RCM_ASSERT_NOW(a_ended_done, clock, reset, state_ff == ST_ENDED, done_ff,
                   "ended state without finished flag")
   `RCM_ASSERT_NEXT(a_reject_holds, clock, reset, adv && !ok_in,
                    $stable(state_ff) && $stable(fill_ff) && $stable(done_ff),
                    "rejected event changed state")
   `RCM_ASSERT_NEXT(a_fault_fill, clock, reset, adv && fault_in, $stable(fill_ff),
                    "queue fault changed the fill count")

endmodule

FILE: tb/sv/rts_cts_mailbox_handshake_top_test.sv
// Self-checking testbench for the RTS/CTS/ACK mailbox handshake controller.
// Drives events through rcm_req_if, predicts every result, and checks rcm_rsp_if.
// Depends on rcm_pkg, rcm_channels and rts_cts_mailbox_handshake_top.
module rts_cts_mailbox_handshake_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import rcm_pkg::*;

   localparam int TOTAL_EVENTS = 1550;
   localparam int STALL_LIMIT  = 2000;
   localparam int MAX_PRINTS   = 40;

   // The kind field reads zero when no message goes out
   localparam kind_type KIND_NONE = KIND_HOLD;

   typedef struct packed {
      logic      send_valid;
      kind_type  send_kind;
      id_type    send_dest;
      tag_type   send_tag;
      state_type state_now;
      logic      finished;
      logic      accepted;
      logic      queue_fault;
      logic      receive_override;
      tag_type   buffer_tag;
      id_type    buffer_dest;
      count_type queue_count;
   } mailbox_result_type;

   typedef struct {
      cmd_type            cmd;
      id_type             src;
      id_type             dst;
      tag_type            tag;
      bit                 typed;
      mailbox_result_type want;
   } script_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rcm_req_if req_ch ();
   rcm_rsp_if rsp_ch ();

   rts_cts_mailbox_handshake_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // Typed-in expectation travels with the transaction it belongs to
   bit                 req_typed;
   mailbox_result_type req_want;

   // Predicted handshake state
   state_type mb_state    = ST_IDLE_EMPTY;
   logic      mb_done     = 1'b0;
   logic      mb_override = 1'b0;
   id_type    mb_target   = '0;
   tag_type   mb_handle   = '0;
   id_type    wait_ids [QUEUE_DEPTH];
   int        wait_head   = 0;
   int        wait_fill   = 0;

   mailbox_result_type due_replies [$];
   script_row_type     intro [$];

   int  issued          = 0;
   int  accepted_events = 0;
   int  replies_checked = 0;
   int  faults_seen     = 0;
   int  rejects_seen    = 0;
   int  mismatches      = 0;
   bit  steady          = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic mailbox_result_type outcome(logic sv, kind_type kind, id_type dest,
                                                  tag_type tag, state_type st, logic fin,
                                                  logic acc, logic flt, logic ovr,
                                                  tag_type btag, id_type bdest,
                                                  count_type cnt);
      return '{sv, kind, dest, tag, st, fin, acc, flt, ovr, btag, bdest, cnt};
   endfunction

   // Advance the predicted controller by one event and return its result
   function automatic mailbox_result_type predict_handshake(cmd_type c, id_type s,
                                                            id_type d, tag_type t);
      mailbox_result_type r;
      state_type          st;
      r          = '0;
      r.accepted = 1'b1;
      st         = mb_state;
      s          = s & ID_MASK;
      d          = d & ID_MASK;

      if (c == CMD_RESTART) begin
         mb_state = ST_IDLE_EMPTY;
      end else if (c == CMD_RTS_IN) begin
         r.send_valid = 1'b1;
         r.send_dest  = s;
         if (st == ST_WAIT_RTS) begin
            r.send_kind = KIND_CTS;
            mb_target   = s;
            mb_override = 1'b1;
            mb_state    = ST_WAIT_MSG;
         end else begin
            // Hold the sender and queue it; drop it when the queue is full
            r.send_kind = KIND_HOLD;
            if (wait_fill >= QUEUE_DEPTH) begin
               r.queue_fault = 1'b1;
            end else begin
               wait_ids[ptr_type'((wait_head + wait_fill) % QUEUE_DEPTH)] = s;
               wait_fill++;
            end
            if (st == ST_IDLE_EMPTY) mb_state = ST_IDLE_QUEUED;
         end
      end else begin
         case (st)
            ST_IDLE_EMPTY, ST_IDLE_QUEUED: begin
               if (c == CMD_INIT_SEND) begin
                  mb_target    = d;
                  mb_handle    = t;
                  r.send_valid = 1'b1;
                  r.send_kind  = KIND_RTS;
                  r.send_dest  = d;
                  mb_state     = ST_RTS_SENT;
               end else if (c == CMD_START_RX_NOQ) begin
                  mb_state = ST_WAIT_RTS;
               end else if (c == CMD_START_RX && st == ST_IDLE_EMPTY) begin
                  mb_state = ST_WAIT_RTS;
               end else if (c == CMD_START_RX) begin
                  // Pop the oldest waiting sender; an empty pop clears to id 0
                  r.send_valid = 1'b1;
                  r.send_kind  = KIND_CTS;
                  if (wait_fill == 0) begin
                     r.queue_fault = 1'b1;
                  end else begin
                     r.send_dest = wait_ids[ptr_type'(wait_head)];
                     wait_head   = (wait_head + 1) % QUEUE_DEPTH;
                     wait_fill--;
                  end
                  mb_target = r.send_dest;
                  mb_state  = ST_WAIT_MSG;
               end else begin
                  r.accepted = 1'b0;
               end
            end
            ST_RTS_SENT, ST_HOLD: begin
               if (c == CMD_HOLD_IN && st == ST_RTS_SENT) begin
                  mb_state = ST_HOLD;
               end else if (c == CMD_CTS_IN) begin
                  r.send_valid = 1'b1;
                  r.send_kind  = KIND_DATA;
                  r.send_dest  = mb_target;
                  r.send_tag   = mb_handle;
                  mb_state     = ST_WAIT_ACK;
               end else if (c != CMD_VALID_CLESS) begin
                  r.accepted = 1'b0;
               end
            end
            ST_WAIT_ACK: begin
               if (c == CMD_ACK_IN) begin
                  mb_done  = 1'b1;
                  mb_state = ST_ENDED;
               end else if (c != CMD_VALID_CLESS) begin
                  r.accepted = 1'b0;
               end
            end
            ST_WAIT_RTS: begin
               if (c == CMD_TIMEOUT || c == CMD_VALID_CLESS) begin
                  mb_target = d;
                  mb_handle = t;
                  mb_done   = 1'b1;
                  mb_state  = ST_ENDED;
               end else begin
                  r.accepted = 1'b0;
               end
            end
            ST_WAIT_MSG: begin
               if (c == CMD_VALID_MSG) begin
                  r.send_valid = 1'b1;
                  r.send_kind  = KIND_ACK;
                  r.send_dest  = s;
                  mb_target    = d;
                  mb_handle    = t;
                  mb_done      = 1'b1;
                  mb_state     = ST_ENDED;
               end else if (c != CMD_TIMEOUT && c != CMD_VALID_CLESS) begin
                  r.accepted = 1'b0;
               end
            end
            default: begin
               // Ended: besides a restart, only the two reset events leave; they clear flags and buffer
               if (c == CMD_RST_Q_EMPTY || c == CMD_RST_Q_PENDING) begin
                  mb_done     = 1'b0;
                  mb_override = 1'b0;
                  mb_target   = '0;
                  mb_handle   = '0;
                  mb_state    = (c == CMD_RST_Q_EMPTY) ? ST_IDLE_EMPTY : ST_IDLE_QUEUED;
               end else begin
                  r.accepted = 1'b0;
               end
            end
         endcase
      end

      r.state_now        = mb_state;
      r.finished         = mb_done;
      r.receive_override = mb_override;
      r.buffer_tag       = mb_handle;
      r.buffer_dest      = mb_target;
      r.queue_count      = count_type'(wait_fill);
      return r;
   endfunction

   task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      if (mismatches <= MAX_PRINTS)
         $display("[%0t] result %0d: %s got %0h want %0h", $realtime, replies_checked,
                  what, got, want);
   endtask

   task automatic check_reply(mailbox_result_type w);
      if (rsp_ch.send_valid !== w.send_valid)
         flag_mismatch("send_valid", 32'(rsp_ch.send_valid), 32'(w.send_valid));
      if (rsp_ch.send_kind !== w.send_kind)
         flag_mismatch("send_kind", 32'(rsp_ch.send_kind), 32'(w.send_kind));
      if (rsp_ch.send_dest !== w.send_dest)
         flag_mismatch("send_dest", 32'(rsp_ch.send_dest), 32'(w.send_dest));
      if (rsp_ch.send_tag !== w.send_tag)
         flag_mismatch("send_tag", 32'(rsp_ch.send_tag), 32'(w.send_tag));
      if (rsp_ch.state_now !== w.state_now)
         flag_mismatch("state_now", 32'(rsp_ch.state_now), 32'(w.state_now));
      if (rsp_ch.finished !== w.finished)
         flag_mismatch("finished", 32'(rsp_ch.finished), 32'(w.finished));
      if (rsp_ch.accepted !== w.accepted)
         flag_mismatch("accepted", 32'(rsp_ch.accepted), 32'(w.accepted));
      if (rsp_ch.queue_fault !== w.queue_fault)
         flag_mismatch("queue_fault", 32'(rsp_ch.queue_fault), 32'(w.queue_fault));
      if (rsp_ch.receive_override !== w.receive_override)
         flag_mismatch("receive_override", 32'(rsp_ch.receive_override),
                       32'(w.receive_override));
      if (rsp_ch.buffer_tag !== w.buffer_tag)
         flag_mismatch("buffer_tag", 32'(rsp_ch.buffer_tag), 32'(w.buffer_tag));
      if (rsp_ch.buffer_dest !== w.buffer_dest)
         flag_mismatch("buffer_dest", 32'(rsp_ch.buffer_dest), 32'(w.buffer_dest));
      if (rsp_ch.queue_count !== w.queue_count)
         flag_mismatch("queue_count", 32'(rsp_ch.queue_count), 32'(w.queue_count));
   endtask

   // Predict on each accepted event, then check each accepted result in order
   always @(posedge clock) begin
      mailbox_result_type want;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            want = predict_handshake(req_ch.cmd, req_ch.source_id, req_ch.dest_id,
                                     req_ch.message_tag);
            if (want.queue_fault) faults_seen++;
            if (!want.accepted) rejects_seen++;
            if (req_typed) want = req_want;
            due_replies.push_back(want);
            accepted_events++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            replies_checked++;
            if (due_replies.size() == 0) flag_mismatch("result with nothing due", 0, 0);
            else check_reply(due_replies.pop_front());
         end
      end
   end

   // Mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   function automatic bit coin();
      return $urandom_range(0, 1) == 1;
   endfunction

   function automatic id_type pick_id();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return ID_MASK;
         default: return id_type'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic tag_type pick_tag();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return tag_type'($urandom_range(0, 65535));
      endcase
   endfunction

   // Receiver pacing: runs of ready, then random stalls
   initial begin : rsp_pacing
      int run;
      int hold;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         run = $urandom_range(1, 16);
         rsp_ch.ready <= 1'b1;
         repeat (run) @(posedge clock);
         hold = steady ? 0 : pick_gap();
         if (hold > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
      end
   end

   // Abort when no transaction moves on either channel for too long
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("No transaction for %0d cycles, %0d results still due", STALL_LIMIT,
               due_replies.size());
      $display("Simulation FAILED");
      $finish;
   end

   // Present one event and hold it until the controller takes it
   task automatic issue(cmd_type c, id_type s, id_type d, tag_type t, bit typed,
                        mailbox_result_type want);
      int gap;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.cmd         <= c;
      req_ch.source_id   <= s;
      req_ch.dest_id     <= d;
      req_ch.message_tag <= t;
      req_typed          <= typed;
      req_want           <= want;
      do @(posedge clock); while (!req_ch.ready);
      issued++;
   endtask

   task automatic issue_rand(cmd_type c);
      issue(c, pick_id(), pick_id(), pick_tag(), 1'b0, '0);
   endtask

   // Drop valid and wait until every expected result has come back
   task automatic drain_replies();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (due_replies.size() != 0);
   endtask

   task automatic add_step(cmd_type c, id_type s, id_type d, tag_type t);
      intro.push_back('{c, s, d, t, 1'b0, '0});
   endtask

   task automatic add_checked(cmd_type c, id_type s, id_type d, tag_type t,
                              mailbox_result_type want);
      intro.push_back('{c, s, d, t, 1'b1, want});
   endtask

   // One random sequence: mostly well-formed flows, some noise and broken ones
   task automatic random_scenario();
      int pick;
      int n;
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 2) == 0) issue_rand(CMD_RESTART);
      if (pick < 35) begin
         // Outbound: RTS, optional HOLD and queued inbound RTS, CTS, data, ACK
         issue_rand(CMD_INIT_SEND);
         if ($urandom_range(0, 2) == 0) issue_rand(CMD_HOLD_IN);
         n = $urandom_range(0, 2);
         repeat (n) issue_rand(CMD_RTS_IN);
         if (coin()) issue_rand(CMD_VALID_CLESS);
         issue_rand(CMD_CTS_IN);
         if (coin()) issue_rand(CMD_VALID_CLESS);
         issue_rand(CMD_ACK_IN);
         issue_rand(coin() ? CMD_RST_Q_EMPTY : CMD_RST_Q_PENDING);
      end else if (pick < 65) begin
         // Inbound: start receive, then RTS and message, or a timeout or connectionless end
         issue_rand(coin() ? CMD_START_RX : CMD_START_RX_NOQ);
         case ($urandom_range(0, 3))
            0, 1: begin
               issue_rand(CMD_RTS_IN);
               issue_rand(CMD_VALID_MSG);
            end
            2: issue_rand(CMD_TIMEOUT);
            default: issue_rand(CMD_VALID_CLESS);
         endcase
         issue_rand(coin() ? CMD_RST_Q_EMPTY : CMD_RST_Q_PENDING);
      end else if (pick < 75) begin
         // Flood the waiting queue, then serve some of it
         n = $urandom_range(2, 20);
         repeat (n) issue_rand(CMD_RTS_IN);
         n = $urandom_range(1, 6);
         repeat (n) begin
            issue_rand(CMD_START_RX);
            issue_rand(CMD_VALID_MSG);
            issue_rand(CMD_RST_Q_PENDING);
         end
      end else if (pick < 90) begin
         n = $urandom_range(1, 6);
         repeat (n) issue_rand(cmd_type'($urandom_range(0, CMD_RESTART)));
      end else begin
         // Broken flow: start a send, then something out of order
         issue_rand(CMD_INIT_SEND);
         issue_rand(cmd_type'($urandom_range(0, CMD_RESTART)));
         issue_rand(CMD_RESTART);
      end
   endtask

   initial begin : stimulus
      bit paused;
      paused = 1'b0;
      req_ch.valid       <= 1'b0;
      req_ch.cmd         <= CMD_RESTART;
      req_ch.source_id   <= '0;
      req_ch.dest_id     <= '0;
      req_ch.message_tag <= '0;
      req_typed          <= 1'b0;
      req_want           <= '0;

      // Directed walk: invalid events, both receive paths, full send, empty pop
      add_checked(CMD_HOLD_IN, 8'h00, 8'h00, 16'h0000,
                  outcome(0, KIND_NONE, 0, 0, ST_IDLE_EMPTY, 0, 0, 0, 0, 0, 0, 0));
      add_checked(CMD_START_RX_NOQ, 8'h00, 8'h00, 16'h0000,
                  outcome(0, KIND_NONE, 0, 0, ST_WAIT_RTS, 0, 1, 0, 0, 0, 0, 0));
      add_checked(CMD_RTS_IN, 8'hFF, 8'h00, 16'h0000,
                  outcome(1, KIND_CTS, 8'hFF, 0, ST_WAIT_MSG, 0, 1, 0, 1, 0, 8'hFF, 0));
      add_checked(CMD_VALID_MSG, 8'hFF, 8'h00, 16'hFFFF,
                  outcome(1, KIND_ACK, 8'hFF, 0, ST_ENDED, 1, 1, 0, 1, 16'hFFFF, 8'h00, 0));
      add_checked(CMD_TIMEOUT, 8'h00, 8'hFF, 16'h1234,
                  outcome(0, KIND_NONE, 0, 0, ST_ENDED, 1, 0, 0, 1, 16'hFFFF, 8'h00, 0));
      add_checked(CMD_RST_Q_EMPTY, 8'h00, 8'h00, 16'h0000,
                  outcome(0, KIND_NONE, 0, 0, ST_IDLE_EMPTY, 0, 1, 0, 0, 0, 0, 0));
      add_step(CMD_INIT_SEND, 8'h00, 8'hFF, 16'hA5C3);
      add_step(CMD_VALID_CLESS, 8'h3C, 8'hC3, 16'h5A5A);
      add_step(CMD_HOLD_IN, 8'h81, 8'h7E, 16'h0001);
      add_step(CMD_RTS_IN, 8'h5A, 8'hA5, 16'h8000);
      add_step(CMD_CTS_IN, 8'h01, 8'h80, 16'h7FFF);
      add_step(CMD_ACK_IN, 8'h80, 8'h01, 16'hFFFE);
      add_step(CMD_RST_Q_PENDING, 8'h00, 8'h00, 16'h0000);
      add_step(CMD_START_RX, 8'h12, 8'h34, 16'h5678);
      add_step(CMD_TIMEOUT, 8'hAA, 8'h55, 16'hAAAA);
      add_step(CMD_RESTART, 8'h55, 8'hAA, 16'h5555);
      add_step(CMD_START_CLESS, 8'hF0, 8'h0F, 16'hF0F0);
      add_step(CMD_START_RX, 8'h0F, 8'hF0, 16'h0F0F);
      add_step(CMD_VALID_CLESS, 8'h7F, 8'hFE, 16'hBEEF);
      add_step(CMD_RST_Q_PENDING, 8'hFF, 8'hFF, 16'hFFFF);
      add_checked(CMD_START_RX, 8'hFF, 8'hFF, 16'hFFFF,
                  outcome(1, KIND_CTS, 8'h00, 0, ST_WAIT_MSG, 0, 1, 1, 0, 0, 8'h00, 0));
      add_step(CMD_RESTART, 8'h00, 8'h00, 16'h0000);
      add_step(CMD_START_RX_NOQ, 8'h11, 8'h22, 16'h3333);
      add_step(CMD_TIMEOUT, 8'h44, 8'hEE, 16'hCAFE);
      add_step(CMD_RST_Q_EMPTY, 8'h00, 8'h00, 16'h0000);

      // Hold reset, then release it at a clock edge
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (intro[i])
         issue(intro[i].cmd, intro[i].src, intro[i].dst, intro[i].tag, intro[i].typed,
               intro[i].want);

      while (issued < TOTAL_EVENTS) begin
         // Every fourth block of 100 events runs with no idling on either side
         steady = ((issued / 100) % 4 == 3);
         if (!paused && issued >= TOTAL_EVENTS / 2) begin
            drain_replies();
            paused = 1'b1;
         end
         random_scenario();
      end

      drain_replies();
      repeat (10) @(posedge clock);

      $display("Ran %0d events, checked %0d results", accepted_events, replies_checked);
      $display("Queue faults %0d, rejected events %0d, mismatches %0d", faults_seen,
               rejects_seen, mismatches);
      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

FILE: rts_cts_mailbox_handshake_top.f
+incdir+design
design/rcm_pkg.sv
design/rcm_channels.sv
design/rts_cts_mailbox_handshake_top.sv
tb/sv/rts_cts_mailbox_handshake_top_test.sv
